>>> src/owm_pkg.sv
// Shared constants and types for the omni wheel mixer.
`timescale 1ns / 1ps

package owm_pkg;

    // Field and register widths
    localparam int STICK_W    = 11;
    localparam int WHEEL_W    = 16;
    localparam int NUM_WHEELS = 4;
    localparam int MS_W       = 14;
    localparam int ARM_W      = 13;
    localparam int LIM_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = NUM_WHEELS * WHEEL_W;

    // Register reset values
    localparam logic [MS_W-1:0]  TOP_SPEED_RST  = MS_W'(2000);
    localparam logic [ARM_W-1:0] WHEEL_ARM_RST  = ARM_W'(1065);
    localparam logic [LIM_W-1:0] SPEED_LIM_RST  = LIM_W'(32767);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_SPEED   = 2'd0,
        CFG_WHEEL_ARM   = 2'd1,
        CFG_SPEED_LIMIT = 2'd2
    } cfg_idx_t;

    // Stick scaling: trunc(scale * stick / 660) through a reciprocal multiply
    localparam int STICK_SPAN  = 660;
    localparam int PROD_W      = 26;
    localparam int MAG_W       = 25;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 35;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / STICK_SPAN);
    localparam int QA_W        = 16;

    // Wheel mixing
    localparam int COS45_Q15 = 23170;
    localparam int TRANS_W   = 17;
    localparam int TC_W      = 33;
    localparam int WA_W      = 30;
    localparam int SUM_W     = 34;
    localparam int Q15_SHIFT = 15;
    localparam int Q15_MASK  = (1 << Q15_SHIFT) - 1;
    localparam int ARM_ALIGN = 3;
    localparam int MIX_W     = SUM_W - Q15_SHIFT;

    // Limiting divider
    localparam int PEAK_W     = 16;
    localparam int NUM_W      = PEAK_W + LIM_W;
    localparam int QUO_W      = 15;
    localparam int DIV_BPS    = 3;
    localparam int DIV_STAGES = QUO_W / DIV_BPS;

    // Pipeline layout
    localparam int PRE_STAGES = 7;
    localparam int NSTG       = PRE_STAGES + DIV_STAGES + 1;
    localparam int DIV_FIRST  = PRE_STAGES;
    localparam int OUT_STAGE  = NSTG - 1;

    typedef logic signed [WHEEL_W-1:0] wheel_t;
    typedef logic [PEAK_W-1:0]         peak_t;
    typedef logic [NUM_W-1:0]          num_t;
    typedef logic [QUO_W-1:0]          quo_t;

endpackage

>>> src/owm_div.sv
// Pipelined restoring divider lane, three quotient bits per stage.
`timescale 1ns / 1ps

module owm_div import owm_pkg::*; (
    input  logic                  aclk,
    input  logic [DIV_STAGES-1:0] stage_en,
    input  num_t                  num,
    input  peak_t                 den,
    output quo_t                  quo
);

    num_t  rem_reg  [DIV_STAGES];
    peak_t den_reg  [DIV_STAGES];
    quo_t  quo_reg  [DIV_STAGES];
    num_t  rem_in   [DIV_STAGES];
    peak_t den_in   [DIV_STAGES];
    quo_t  quo_in   [DIV_STAGES];
    num_t  rem_next [DIV_STAGES];
    quo_t  quo_next [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_src
        if (g == 0) begin : g_head
            assign rem_in[g] = num;
            assign den_in[g] = den;
            assign quo_in[g] = '0;
        end else begin : g_body
            assign rem_in[g] = rem_reg[g-1];
            assign den_in[g] = den_reg[g-1];
            assign quo_in[g] = quo_reg[g-1];
        end
    end

    always_comb begin
        num_t trial;
        num_t rem_v;
        quo_t quo_v;
        for (int k = 0; k < DIV_STAGES; k++) begin
            rem_v = rem_in[k];
            quo_v = quo_in[k];
            for (int j = 0; j < DIV_BPS; j++) begin
                trial = NUM_W'(den_in[k]) << (QUO_W - 1 - k * DIV_BPS - j);
                if (rem_v >= trial) begin
                    rem_v = rem_v - trial;
                    quo_v[QUO_W - 1 - k * DIV_BPS - j] = 1'b1;
                end
            end
            rem_next[k] = rem_v;
            quo_next[k] = quo_v;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (stage_en[k]) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_in[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

>>> src/omni_wheel_mixer_with_limiting_top.sv
// Top level of the X-chassis omni wheel mixer with proportional speed limiting.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata: strafe, forward, rotate (11b ea)
//  m_       | out       | m_tvalid/m_tready  | m_tdata: four wheels (16b ea); m_tuser: limited
//  cfg_     | in        | cfg_we (no wait)   | cfg_index, cfg_wdata
//
//  A word enters every cycle unless the pipe is full and stalled; the depth is set by
//  the 7 arithmetic stages, the 5-stage limiting divider and the output register.
//  Each stage keeps its own valid bit and loads whenever it is empty or the stage
//  after it moves, so bubbles close up and a stalled output does not stop intake
//  until the pipe is full. Reset (aresetn, synchronous) empties the pipe and loads
//  the register defaults. Registers must only be written while the pipe is empty.

module omni_wheel_mixer_with_limiting_top import owm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [10:0] stick_strafe, [21:11] stick_forward, [32:22] stick_rotate, rest zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] wheel_front_left, [31:16] wheel_front_right,
    // [47:32] wheel_back_right, [63:48] wheel_back_left
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // [0] was_limited
    output logic [0:0]             m_tuser,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MS_W-1:0]  top_speed_reg;
    logic [ARM_W-1:0] wheel_arm_reg;
    logic [LIM_W-1:0] speed_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_speed_reg   <= TOP_SPEED_RST;
            wheel_arm_reg   <= WHEEL_ARM_RST;
            speed_limit_reg <= SPEED_LIM_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TOP_SPEED:   top_speed_reg   <= cfg_wdata[MS_W-1:0];
                CFG_WHEEL_ARM:   wheel_arm_reg   <= cfg_wdata[ARM_W-1:0];
                CFG_SPEED_LIMIT: speed_limit_reg <= cfg_wdata[LIM_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and load enables
    // ------------------------------------------------------------------
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    // A stage loads when it is empty or its contents move on this edge.
    always_comb begin
        en[NSTG-1] = !v_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    v_reg[k] <= (k == 0) ? s_tvalid : v_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[OUT_STAGE];

    // ------------------------------------------------------------------
    // Stage 0: scale each stick by the full-stick speed (rotation by twice that)
    // ------------------------------------------------------------------
    logic signed [STICK_W-1:0] stick [3];
    logic signed [PROD_W-1:0]  prod_next [3];
    logic signed [PROD_W-1:0]  prod_reg  [3];

    assign stick[0] = $signed(s_tdata[STICK_W-1:0]);
    assign stick[1] = $signed(s_tdata[2*STICK_W-1:STICK_W]);
    assign stick[2] = $signed(s_tdata[3*STICK_W-1:2*STICK_W]);

    always_comb begin
        prod_next[0] = PROD_W'($signed({1'b0, top_speed_reg})) * PROD_W'(stick[0]);
        prod_next[1] = PROD_W'($signed({1'b0, top_speed_reg})) * PROD_W'(stick[1]);
        prod_next[2] = PROD_W'($signed({1'b0, top_speed_reg, 1'b0})) * PROD_W'(stick[2]);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            prod_reg <= prod_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: magnitude, then estimate of magnitude / 660 by reciprocal
    // (the estimate is the true quotient or one below it)
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] mag_next [3];
    logic [MAG_W-1:0] mag_reg  [3];
    logic [QA_W-1:0]  qa_next  [3];
    logic [QA_W-1:0]  qa_reg   [3];
    logic [2:0]       neg_reg;

    always_comb begin
        logic [MAG_W+RECIP_W-1:0] full;
        for (int c = 0; c < 3; c++) begin
            mag_next[c] = prod_reg[c][PROD_W-1] ? MAG_W'(-prod_reg[c]) : MAG_W'(prod_reg[c]);
            full        = (MAG_W+RECIP_W)'(mag_next[c]) * (MAG_W+RECIP_W)'(RECIP);
            qa_next[c]  = full[RECIP_SHIFT +: QA_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            mag_reg <= mag_next;
            qa_reg  <= qa_next;
            for (int c = 0; c < 3; c++) begin
                neg_reg[c] <= prod_reg[c][PROD_W-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: correct the quotient, restore the sign, saturate -> vx, vy, wz
    // ------------------------------------------------------------------
    wheel_t vel_next [3];
    wheel_t vel_reg  [3];

    always_comb begin
        logic [MAG_W-1:0] back;
        logic [MAG_W-1:0] rem;
        logic [QA_W:0]    q;
        for (int c = 0; c < 3; c++) begin
            back = MAG_W'(qa_reg[c]) * MAG_W'(STICK_SPAN);
            rem  = mag_reg[c] - back;
            q    = {1'b0, qa_reg[c]} + (QA_W+1)'(rem >= MAG_W'(STICK_SPAN));
            if (neg_reg[c]) begin
                vel_next[c] = (q > (QA_W+1)'(32768)) ? wheel_t'(-32768) : WHEEL_W'(-q);
            end else begin
                vel_next[c] = (q > (QA_W+1)'(32767)) ? wheel_t'(32767) : WHEEL_W'(q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            vel_reg <= vel_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: translation sums times cos45 (Q15), rotation times arm (Q12)
    // ------------------------------------------------------------------
    logic signed [TRANS_W-1:0] trans [NUM_WHEELS];
    logic signed [TC_W-1:0]    tc_next [NUM_WHEELS];
    logic signed [TC_W-1:0]    tc_reg  [NUM_WHEELS];
    logic signed [WA_W-1:0]    wa_next;
    logic signed [WA_W-1:0]    wa_reg;

    always_comb begin
        trans[0] =  TRANS_W'(vel_reg[0]) + TRANS_W'(vel_reg[1]);
        trans[1] = -TRANS_W'(vel_reg[0]) + TRANS_W'(vel_reg[1]);
        trans[2] = -TRANS_W'(vel_reg[0]) - TRANS_W'(vel_reg[1]);
        trans[3] =  TRANS_W'(vel_reg[0]) - TRANS_W'(vel_reg[1]);
        for (int i = 0; i < NUM_WHEELS; i++) begin
            tc_next[i] = TC_W'(trans[i]) * $signed(TC_W'(COS45_Q15));
        end
        wa_next = WA_W'(vel_reg[2]) * $signed(WA_W'(wheel_arm_reg));
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            tc_reg <= tc_next;
            wa_reg <= wa_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: align to a common Q15 scale, truncate toward zero, saturate
    // ------------------------------------------------------------------
    wheel_t wmix_next [NUM_WHEELS];
    wheel_t wmix_reg  [NUM_WHEELS];

    always_comb begin
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] adj;
        logic signed [SUM_W-1:0] shifted;
        logic signed [MIX_W-1:0] q;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            sum = SUM_W'(tc_reg[i]) + (SUM_W'(wa_reg) <<< ARM_ALIGN);
            if (sum[SUM_W-1]) begin
                adj = sum + $signed(SUM_W'(Q15_MASK));
            end else begin
                adj = sum;
            end
            shifted = adj >>> Q15_SHIFT;
            q       = shifted[MIX_W-1:0];
            if (q > $signed(MIX_W'(32767))) begin
                wmix_next[i] = wheel_t'(32767);
            end else if (q < -$signed(MIX_W'(32768))) begin
                wmix_next[i] = wheel_t'(-32768);
            end else begin
                wmix_next[i] = q[WHEEL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            wmix_reg <= wmix_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: wheel magnitudes and pairwise maxima
    // ------------------------------------------------------------------
    peak_t  wabs_next [NUM_WHEELS];
    peak_t  wabs_reg  [NUM_WHEELS];
    wheel_t w5_reg    [NUM_WHEELS];
    peak_t  pair_next [2];
    peak_t  pair_reg  [2];

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            wabs_next[i] = wmix_reg[i][WHEEL_W-1] ? (~PEAK_W'(wmix_reg[i]) + PEAK_W'(1))
                                                  : PEAK_W'(wmix_reg[i]);
        end
        pair_next[0] = (wabs_next[0] > wabs_next[1]) ? wabs_next[0] : wabs_next[1];
        pair_next[1] = (wabs_next[2] > wabs_next[3]) ? wabs_next[2] : wabs_next[3];
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            wabs_reg <= wabs_next;
            w5_reg   <= wmix_reg;
            pair_reg <= pair_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: peak, limit decision, dividend |w| * limit
    // ------------------------------------------------------------------
    peak_t  peak_next;
    peak_t  peak_reg;
    logic   lim_next;
    logic   lim_reg;
    num_t   num_next [NUM_WHEELS];
    num_t   num_reg  [NUM_WHEELS];
    wheel_t w6_reg   [NUM_WHEELS];

    always_comb begin
        peak_next = (pair_reg[0] > pair_reg[1]) ? pair_reg[0] : pair_reg[1];
        lim_next  = peak_next > PEAK_W'(speed_limit_reg);
        for (int i = 0; i < NUM_WHEELS; i++) begin
            num_next[i] = NUM_W'(wabs_reg[i]) * NUM_W'(speed_limit_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            peak_reg <= peak_next;
            lim_reg  <= lim_next;
            num_reg  <= num_next;
            w6_reg   <= w5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: |w| * limit / peak, one lane per wheel; the unscaled
    // wheels and the limit flag ride alongside
    // ------------------------------------------------------------------
    quo_t   quo [NUM_WHEELS];
    wheel_t side_w_reg   [DIV_STAGES][NUM_WHEELS];
    logic   side_lim_reg [DIV_STAGES];

    for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_lane
        owm_div u_div (
            .aclk     (aclk),
            .stage_en (en[DIV_FIRST +: DIV_STAGES]),
            .num      (num_reg[i]),
            .den      (peak_reg),
            .quo      (quo[i])
        );
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (en[DIV_FIRST + k]) begin
                if (k == 0) begin
                    side_w_reg[k]   <= w6_reg;
                    side_lim_reg[k] <= lim_reg;
                end else begin
                    side_w_reg[k]   <= side_w_reg[(k == 0) ? 0 : k - 1];
                    side_lim_reg[k] <= side_lim_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: pick scaled or unscaled wheels, restore sign
    // ------------------------------------------------------------------
    wheel_t out_next [NUM_WHEELS];
    wheel_t out_reg  [NUM_WHEELS];
    logic   out_lim_reg;

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            if (!side_lim_reg[DIV_STAGES-1]) begin
                out_next[i] = side_w_reg[DIV_STAGES-1][i];
            end else if (side_w_reg[DIV_STAGES-1][i][WHEEL_W-1]) begin
                out_next[i] = -WHEEL_W'(quo[i]);
            end else begin
                out_next[i] = WHEEL_W'(quo[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[OUT_STAGE]) begin
            out_reg     <= out_next;
            out_lim_reg <= side_lim_reg[DIV_STAGES-1];
        end
    end

    assign m_tdata = {out_reg[3], out_reg[2], out_reg[1], out_reg[0]};
    assign m_tuser = out_lim_reg;

endmodule
